// ----- src/prs_pkg.sv -----
package prs_pkg;

	localparam int DIM_W     = 13;
	localparam int COORD_W   = 12;
	localparam int PIX_W     = 32;
	localparam int MAX_SCALE = 8;
	localparam int OFS_W     = $clog2(MAX_SCALE);
	localparam int ACC_W     = DIM_W + OFS_W;
	localparam int IDX_W     = 2;
	localparam int OUT_W     = 2 * COORD_W + PIX_W;

	localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(4096);
	localparam logic [DIM_W-1:0] DIM_ONE = DIM_W'(1);

	localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_DST_WIDTH  = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_DST_HEIGHT = IDX_W'(3);

	typedef struct packed {
		logic load_pix;
		logic div_init;
		logic div_step;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
		logic last;
	} dp_sts_t;

endpackage

// ----- src/prs_ctrl.sv -----
module prs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic               cfg_wr,
	input  prs_pkg::dp_sts_t   sts,
	output prs_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

	localparam int CNT_W = $clog2(prs_pkg::DIM_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(prs_pkg::DIM_W - 1);

	state_t           state_q;
	logic             dirty_q;
	logic [CNT_W-1:0] cnt_q;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.load_pix = s_tvalid && s_tready;
		cmd.div_init = cmd.load_pix && dirty_q;
		cmd.div_step = (state_q == ST_DIV);
		cmd.emit     = (state_q == ST_EMIT) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dirty_q <= 1'b1;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load_pix) begin
						cnt_q   <= '0;
						state_q <= dirty_q ? ST_DIV : ST_EMIT;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_LAST) begin
						dirty_q <= 1'b0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (cmd.emit && sts.last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg_wr) begin
				dirty_q <= 1'b1;
			end
		end
	end

endmodule

// ----- src/prs_dpath.sv -----
module prs_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr,
	input  logic [prs_pkg::IDX_W-1:0]           cfg_idx,
	input  logic [prs_pkg::DIM_W-1:0]           cfg_val,
	input  logic [prs_pkg::PIX_W-1:0]           pix_in,
	input  prs_pkg::ctrl_cmd_t                  cmd,
	output prs_pkg::dp_sts_t                    sts,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [prs_pkg::OUT_W-1:0]           out_data,
	output logic                                out_last
);

	localparam int DW = prs_pkg::DIM_W;
	localparam int CW = prs_pkg::COORD_W;
	localparam int OW = prs_pkg::OFS_W;
	localparam int AW = prs_pkg::ACC_W;
	localparam logic [OW-1:0] OFS_MAX = OW'(prs_pkg::MAX_SCALE - 1);

	function automatic logic [DW-1:0] eff_dim(input logic [DW-1:0] v);
		logic [DW-1:0] r;
		r = v;
		if (v == '0) r = prs_pkg::DIM_ONE;
		if (v > prs_pkg::MAX_DIM) r = prs_pkg::MAX_DIM;
		return r;
	endfunction

	// one restoring-division step: {remainder, quotient shift register}
	function automatic logic [2*DW-1:0] div_step(input logic [DW-1:0] rem,
			input logic [DW-1:0] quo, input logic [DW-1:0] dvs);
		logic [DW:0]   t;
		logic [DW-1:0] r;
		logic          b;
		t = {rem, quo[DW-1]};
		b = (t >= {1'b0, dvs});
		r = b ? DW'(t - {1'b0, dvs}) : t[DW-1:0];
		return {r, quo[DW-2:0], b};
	endfunction

	logic [DW-1:0] sw_raw_q, sh_raw_q, dw_raw_q, dh_raw_q;
	logic [DW-1:0] sw, sh, dw, dh;

	logic [DW-1:0] qx_q, rx_q, qy_q, ry_q;

	logic [CW-1:0] col_cnt_q, row_cnt_q, col_base_q, row_base_q;
	logic [DW-1:0] col_rem_q, row_rem_q;

	logic [prs_pkg::PIX_W-1:0] pix_q;
	logic [OW-1:0]             ox_q, oy_q;
	logic [AW-1:0]             accx_q, accy_q;

	logic          out_valid_q, out_last_q;
	logic [CW-1:0] out_x_q, out_y_q;
	logic [prs_pkg::PIX_W-1:0] out_pix_q;

	logic [AW-1:0] accx_nxt, accy_nxt;
	logic [DW-1:0] x_cur, y_cur;
	logic          x_more, y_more, last;
	logic          col_end, row_end;
	logic [DW:0]   col_sum, row_sum;
	logic          col_ge, row_ge;
	logic [2*DW-1:0] dx_nxt, dy_nxt;

	assign sw = eff_dim(sw_raw_q);
	assign sh = eff_dim(sh_raw_q);
	assign dw = eff_dim(dw_raw_q);
	assign dh = eff_dim(dh_raw_q);

	assign accx_nxt = accx_q + AW'(sw);
	assign accy_nxt = accy_q + AW'(sh);
	assign x_cur    = DW'(col_base_q) + DW'(ox_q);
	assign y_cur    = DW'(row_base_q) + DW'(oy_q);
	assign x_more   = (ox_q != OFS_MAX) && (accx_nxt < AW'(dw)) && ((x_cur + DW'(1)) < dw);
	assign y_more   = (oy_q != OFS_MAX) && (accy_nxt < AW'(dh)) && ((y_cur + DW'(1)) < dh);
	assign last     = !x_more && !y_more;

	assign col_end = (DW'(col_cnt_q) + DW'(1)) >= sw;
	assign row_end = (DW'(row_cnt_q) + DW'(1)) >= sh;
	assign col_sum = {1'b0, col_rem_q} + {1'b0, rx_q};
	assign row_sum = {1'b0, row_rem_q} + {1'b0, ry_q};
	assign col_ge  = col_sum >= {1'b0, sw};
	assign row_ge  = row_sum >= {1'b0, sh};

	assign dx_nxt = div_step(rx_q, qx_q, sw);
	assign dy_nxt = div_step(ry_q, qy_q, sh);

	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.last     = last;

	assign out_valid = out_valid_q;
	assign out_data  = {out_pix_q, out_y_q, out_x_q};
	assign out_last  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_raw_q <= prs_pkg::DIM_ONE;
			sh_raw_q <= prs_pkg::DIM_ONE;
			dw_raw_q <= prs_pkg::DIM_ONE;
			dh_raw_q <= prs_pkg::DIM_ONE;
		end else if (cfg_wr) begin
			case (cfg_idx)
				prs_pkg::REG_SRC_WIDTH:  sw_raw_q <= cfg_val;
				prs_pkg::REG_SRC_HEIGHT: sh_raw_q <= cfg_val;
				prs_pkg::REG_DST_WIDTH:  dw_raw_q <= cfg_val;
				prs_pkg::REG_DST_HEIGHT: dh_raw_q <= cfg_val;
				default: ;
			endcase
		end
	end

	// step quotient and remainder of dst/src per axis
	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			qx_q <= dw;
			rx_q <= '0;
			qy_q <= dh;
			ry_q <= '0;
		end else if (cmd.div_step) begin
			{rx_q, qx_q} <= dx_nxt;
			{ry_q, qy_q} <= dy_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q  <= '0;
			row_cnt_q  <= '0;
			col_base_q <= '0;
			row_base_q <= '0;
			col_rem_q  <= '0;
			row_rem_q  <= '0;
		end else if (cfg_wr) begin
			col_cnt_q  <= '0;
			row_cnt_q  <= '0;
			col_base_q <= '0;
			row_base_q <= '0;
			col_rem_q  <= '0;
			row_rem_q  <= '0;
		end else if (cmd.emit && last) begin
			if (col_end) begin
				col_cnt_q  <= '0;
				col_base_q <= '0;
				col_rem_q  <= '0;
				if (row_end) begin
					row_cnt_q  <= '0;
					row_base_q <= '0;
					row_rem_q  <= '0;
				end else begin
					row_cnt_q  <= row_cnt_q + CW'(1);
					row_rem_q  <= row_ge ? DW'(row_sum - {1'b0, sh}) : row_sum[DW-1:0];
					row_base_q <= CW'(DW'(row_base_q) + qy_q + DW'(row_ge));
				end
			end else begin
				col_cnt_q  <= col_cnt_q + CW'(1);
				col_rem_q  <= col_ge ? DW'(col_sum - {1'b0, sw}) : col_sum[DW-1:0];
				col_base_q <= CW'(DW'(col_base_q) + qx_q + DW'(col_ge));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_pix) begin
			pix_q  <= pix_in;
			ox_q   <= '0;
			oy_q   <= '0;
			accx_q <= '0;
			accy_q <= '0;
		end else if (cmd.emit && !last) begin
			if (x_more) begin
				ox_q   <= ox_q + OW'(1);
				accx_q <= accx_nxt;
			end else begin
				ox_q   <= '0;
				accx_q <= '0;
				oy_q   <= oy_q + OW'(1);
				accy_q <= accy_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_x_q    <= x_cur[CW-1:0];
			out_y_q    <= y_cur[CW-1:0];
			out_pix_q  <= pix_q;
			out_last_q <= last;
		end
	end

endmodule

// ----- src/pixel_replicating_scaler.sv -----
// Nearest-neighbour scaler: source pixels enter in raster order and each one
// leaves as one to 64 destination writes (coordinate and pixel), row offset
// outer, column offset inner, the final write of a pixel marked with tlast.
// Replication is limited to 8 per axis and writes outside the destination are
// dropped. Sizes 0 act as 1 and sizes above 4096 as 4096. Any register write
// restarts the frame at column 0, row 0. A pixel is accepted only while the
// sequencer is idle, and its writes leave one at a time through the single
// write register on the output side; a stalled output holds the sequencer.
// The first pixel after a register write or reset also waits while the
// bit-serial dividers work out the dst/src step on each axis.
module pixel_replicating_scaler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // source_pixel[31:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // dest_x[11:0], dest_y[23:12], dest_pixel[55:24]
	output logic        m_tlast   // last_write
);

	prs_pkg::ctrl_cmd_t cmd;
	prs_pkg::dp_sts_t   sts;
	logic               cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	prs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cfg_wr   (cfg_wr),
		.sts      (sts),
		.cmd      (cmd)
	);

	prs_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.cfg_idx   (cfg_index),
		.cfg_val   (cfg_data),
		.pix_in    (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_last  (m_tlast)
	);

	a_one_pixel_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("source beat accepted while a pixel is still in progress");

	a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("write issued while output register is occupied and stalled");

	a_done_leaves_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_tready) |-> m_tvalid && m_tlast)
		else $error("pixel finished without a last write on the output");

endmodule

// ----- test/scaler_check.sv -----
module scaler_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,  // source_pixel[31:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,  // dest_x[11:0], dest_y[23:12], dest_pixel[55:24]
	input  logic        m_tlast,  // last_write
	output int          mismatches,
	output int          pending,
	output int          writes_checked
);
	import prs_pkg::*;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [PIX_W-1:0]   pix;
		logic               last;
	} dest_write_t;

	dest_write_t writes_due[$];

	logic [DIM_W-1:0]   src_w, src_h, dst_w, dst_h;
	logic [COORD_W-1:0] col_cnt, row_cnt, col_base, row_base;
	logic [DIM_W-1:0]   col_rem, row_rem;

	function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v);
		if (v == '0)
			return DIM_ONE;
		if (v > MAX_DIM)
			return MAX_DIM;
		return v;
	endfunction

	function automatic int unsigned copies(input int unsigned dst, input int unsigned src);
		int unsigned n;
		n = (dst + src - 1) / src;
		return (n > MAX_SCALE) ? MAX_SCALE : n;
	endfunction

	task automatic restart_frame();
		col_cnt  = '0;
		row_cnt  = '0;
		col_base = '0;
		row_base = '0;
		col_rem  = '0;
		row_rem  = '0;
	endtask

	task automatic apply_reg(input logic [IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
		case (idx)
			REG_SRC_WIDTH:  src_w = val;
			REG_SRC_HEIGHT: src_h = val;
			REG_DST_WIDTH:  dst_w = val;
			REG_DST_HEIGHT: dst_h = val;
		endcase
		restart_frame();
	endtask

	task automatic expand_pixel(input logic [PIX_W-1:0] pix);
		int unsigned sw, sh, dw, dh, cols, rows, acc, q, ox, oy;
		dest_write_t w;
		sw = clamp_dim(src_w);
		sh = clamp_dim(src_h);
		dw = clamp_dim(dst_w);
		dh = clamp_dim(dst_h);
		cols = copies(dw, sw);
		rows = copies(dh, sh);
		// writes beyond the destination edge are dropped
		if (32'(col_base) >= dw)
			cols = 0;
		else if (col_base + cols > dw)
			cols = dw - col_base;
		if (32'(row_base) >= dh)
			rows = 0;
		else if (row_base + rows > dh)
			rows = dh - row_base;
		for (oy = 0; oy < rows; oy++)
			for (ox = 0; ox < cols; ox++) begin
				w.x    = COORD_W'(col_base + ox);
				w.y    = COORD_W'(row_base + oy);
				w.pix  = pix;
				w.last = (oy == rows - 1) && (ox == cols - 1);
				writes_due.push_back(w);
			end

		if (32'(col_cnt) + 1 >= sw) begin
			col_cnt  = '0;
			col_base = '0;
			col_rem  = '0;
			if (32'(row_cnt) + 1 >= sh) begin
				row_cnt  = '0;
				row_base = '0;
				row_rem  = '0;
			end else begin
				row_cnt++;
				acc = row_rem + dh;
				q = acc / sh;
				row_base += COORD_W'(q);
				row_rem = DIM_W'(acc - q * sh);
			end
		end else begin
			col_cnt++;
			acc = col_rem + dw;
			q = acc / sw;
			col_base += COORD_W'(q);
			col_rem = DIM_W'(acc - q * sw);
		end
	endtask

	task automatic check_write();
		dest_write_t got, want;
		got.x    = m_tdata[COORD_W-1:0];
		got.y    = m_tdata[2*COORD_W-1:COORD_W];
		got.pix  = m_tdata[OUT_W-1:2*COORD_W];
		got.last = m_tlast;
		writes_checked++;
		if (writes_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected write beat: x=%0d y=%0d pixel=%h last=%b",
					got.x, got.y, got.pix, got.last);
		end else begin
			want = writes_due.pop_front();
			if (got.x !== want.x || got.y !== want.y || got.pix !== want.pix ||
					got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("write mismatch: expected x=%0d y=%0d pixel=%h last=%b, got x=%0d y=%0d pixel=%h last=%b",
						want.x, want.y, want.pix, want.last,
						got.x, got.y, got.pix, got.last);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w = DIM_ONE;
			src_h = DIM_ONE;
			dst_w = DIM_ONE;
			dst_h = DIM_ONE;
			restart_frame();
			writes_due.delete();
			mismatches     = 0;
			pending        = 0;
			writes_checked = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_write();
			if (cfg_valid && cfg_ready)
				apply_reg(cfg_index, cfg_data);
			if (s_tvalid && s_tready)
				expand_pixel(s_tdata);
			pending = writes_due.size();
		end
	end

endmodule

// ----- test/testbench.sv -----
module testbench;
	import prs_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int RANDOM_PIXELS = 260;

	logic             clk;
	logic             arst_n;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0] cfg_data;
	logic             s_tvalid;
	logic             s_tready;
	logic [PIX_W-1:0] s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic             m_tlast;

	int mismatches, pending, writes_checked;
	int send_idle_pct, recv_idle_pct;
	int pixels_sent, reg_writes, cycles;
	logic [DIM_W-1:0] size_reg [4];

	pixel_replicating_scaler dut (.*);

	scaler_check u_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle_pct);

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d writes still due", cycles, pending);
		$display("CHECK FAILED");
		$finish;
	end

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		size_reg[idx] = val;
		reg_writes++;
	endtask

	// hold the source side off until every due write has come out
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic resize(input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh,
			input logic [DIM_W-1:0] dw, input logic [DIM_W-1:0] dh);
		settle();
		write_reg(REG_SRC_WIDTH, sw);
		write_reg(REG_SRC_HEIGHT, sh);
		write_reg(REG_DST_WIDTH, dw);
		write_reg(REG_DST_HEIGHT, dh);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_pixel(input logic [PIX_W-1:0] pix);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pix;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		pixels_sent++;
	endtask

	task automatic set_idling(input int sent);
		if (sent < RANDOM_PIXELS / 3) begin
			send_idle_pct = 29;
			recv_idle_pct = 67;
		end else if (sent < 2 * RANDOM_PIXELS / 3) begin
			send_idle_pct = 67;
			recv_idle_pct = 29;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
	endtask

	function automatic logic [DIM_W-1:0] pick_size();
		case ($urandom_range(15))
			0:       return '0;
			1:       return DIM_W'(MAX_DIM - 1 + $urandom_range(2));
			2:       return '1;
			3:       return DIM_W'($urandom_range(8191));
			default: return DIM_W'($urandom_range(1, 12));
		endcase
	endfunction

	initial begin
		int burst, random_sent;
		logic [IDX_W-1:0] idx;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		send_idle_pct = 29;
		recv_idle_pct = 67;
		pixels_sent   = 0;
		reg_writes    = 0;
		random_sent   = 0;
		size_reg = '{default: DIM_ONE};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset sizes: one write per pixel, frame wraps on every beat
		send_pixel('0);
		send_pixel('1);
		send_pixel(32'hAAAA_AAAA);
		send_pixel(32'h5555_5555);
		// 3x2 onto 7x5, a full frame and the wrap
		resize(13'd3, 13'd2, 13'd7, 13'd5);
		repeat (7) send_pixel($urandom);
		// oversize destination, replication clamped on both axes
		resize(13'd1, 13'd1, '1, 13'd4097);
		repeat (2) send_pixel($urandom);
		// zero sizes act as one, tall source onto a single row
		resize('0, '1, '0, 13'd1);
		repeat (3) send_pixel($urandom);
		// downscale
		resize(13'd5, 13'd3, 13'd2, 13'd2);
		repeat (4) send_pixel($urandom);

		while (random_sent < RANDOM_PIXELS) begin
			if ($urandom_range(3) == 0) begin
				settle();
				idx = IDX_W'($urandom_range(3));
				write_reg(idx, $urandom_range(1) ? size_reg[idx] : pick_size());
				cfg_valid <= 1'b0;
			end else begin
				resize(pick_size(), pick_size(), pick_size(), pick_size());
			end
			burst = $urandom_range(10, 40);
			if (burst > RANDOM_PIXELS - random_sent)
				burst = RANDOM_PIXELS - random_sent;
			repeat (burst) begin
				set_idling(random_sent);
				send_pixel($urandom);
				random_sent++;
			end
		end

		settle();
		repeat (50) @(negedge clk);
		$display("%0d source pixels, %0d register writes, %0d writes compared",
			pixels_sent, reg_writes, writes_checked);
		$display("upscale with clamping, downscale, zero and oversize sizes,");
		$display("row and frame wrap, stalls on both sides");
		if (mismatches == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
